>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on the next edge
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/plpe_pkg.sv
// shared types, constants and helpers for the piecewise linear path evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package plpe_pkg;
   localparam int MaxPointsDef = 64;
   localparam int DimDef       = 4;
   localparam int FracBitsDef  = 16;

   typedef enum logic [2:0] {
      FUNC_STAGE = 3'd0, FUNC_APPEND = 3'd1, FUNC_CLEAR = 3'd2,
      FUNC_EVAL = 3'd3, FUNC_DERIV = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_CLAMP_FIRST = 3'd1, ST_CLAMP_LAST = 3'd2,
      ST_BAD_INTERVAL = 3'd3, ST_FULL = 3'd4, ST_EMPTY = 3'd5
   } status_type;

   // divider request and reply
   typedef struct packed {
      logic        start;
      logic [63:0] num;   // signed
      logic [31:0] den;   // positive
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;   // signed floor quotient
   } div_rsp_type;

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -66'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

>>> rtl/plpe_div.sv
// shared serial divider: signed 64-bit numerator by positive 32-bit divisor,
// floor quotient, one bit per cycle. uses plpe_pkg
`timescale 1ns / 1ps
`default_nettype none
module plpe_div
   import plpe_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire div_req_type req,
   output div_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [63:0] mag;
   logic        nz;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff[31:0], quo_ff[63]} - {1'b0, den_ff};
      mag     = req.num[63] ? (~req.num + 64'd1) : req.num;
      nz      = (rem_ff != 33'd0);
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         quo_in  = mag;
         rem_in  = 33'd0;
         den_in  = req.den;
         neg_in  = req.num[63];
      end else if (busy_ff) begin
         if (cnt_ff == 7'd64) begin
            // floor for negative numerators
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) quo_in = ~quo_ff + 64'd1 - {63'd0, nz};
         end else begin
            cnt_in = cnt_ff + 7'd1;
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], quo_ff[63]};
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule
`default_nettype wire

>>> rtl/piecewise_linear_path_eval_top.sv
// piecewise linear path evaluator top: sequencer, point memories, staging regs
// uses plpe_pkg and plpe_div
//
// channel | dir | fields
// req_    | in  | tdata {query_time, point_dt, coord_value, coord_index}, tuser func
// rsp_    | out | tdata {coord_index_out, coord_out}, tuser status, tlast last
// csr_    | in  | wdata dims_in_use
//
// stage, clear, unused codes: req_tready stays high; append: busy in S_APP_RD, then
// S_APP_WR per coordinate, then S_OUT; evaluate: S_SRCH_RD, S_SRCH_CMP per search step
// (about log2 of the count), S_PREV_RD, S_INTV for the interval, a divide for u, then
// S_CRD_RD, S_CRD_A, S_CRD_B per coordinate beat (no S_CRD_B when clamped); derivative:
// a divide per coordinate beat unless clamped. reset clears count and staged vector, sets
// dims_in_use to 4; req_tready low while busy; an unaccepted result beat holds the sequencer
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_path_eval_top
   import plpe_pkg::*;
#(
   parameter int MAX_POINTS = MaxPointsDef,
   parameter int DIM        = DimDef,
   parameter int FRAC_BITS  = FracBitsDef
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [3:0] coord_index, [35:4] coord_value, [67:36] point_dt, [99:68] query_time
   input  wire  [103:0] req_tdata,
   // [2:0] func
   input  wire  [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [31:0] coord_out, [35:32] coord_index_out
   output logic [39:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  wire         csr_wen,
   input  wire  [4:0]  csr_wdata
);
   localparam int PW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int AW = $clog2(MAX_POINTS * DIM);

   typedef enum logic [3:0] {
      S_IDLE, S_APP_RD, S_APP_WR, S_SRCH_RD, S_SRCH_CMP, S_PREV_RD, S_INTV,
      S_DIV_WAIT, S_CRD_RD, S_CRD_A, S_CRD_B, S_CRD_DIV, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  dims_ff, dims_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] staged_ff [16];
   logic [2:0]  func_ff, func_in;
   logic signed [31:0] q_ff, q_in, dt_ff, dt_in;
   logic [CW-1:0] lo_ff, lo_in, len_ff, len_in;
   logic signed [31:0] tnext_ff, tnext_in, tprev_ff, tprev_in;
   logic [FRAC_BITS:0] u_ff, u_in;
   logic signed [31:0] ca_ff, ca_in;
   logic [DW-1:0] j_ff, j_in;
   logic [39:0] odata_ff, odata_in;
   logic [2:0]  ostat_ff, ostat_in;
   logic        olast_ff, olast_in, ovalid_ff, ovalid_in;
   logic [2:0]  st_ff, st_in;

   // memories
   logic [31:0] times_mem [MAX_POINTS];
   logic [31:0] coords_mem [MAX_POINTS * DIM];
   logic          t_we, c_we;
   logic [PW-1:0] t_addr;
   logic [AW-1:0] c_addr;
   logic [31:0]   t_wd, c_wd, t_rd_ff, c_rd_ff;

   always_ff @(posedge clock) begin
      if (t_we) times_mem[t_addr] <= t_wd;
      t_rd_ff <= times_mem[t_addr];
      if (c_we) coords_mem[c_addr] <= c_wd;
      c_rd_ff <= coords_mem[c_addr];
   end

   div_req_type dreq;
   div_rsp_type drsp;
   plpe_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [DW:0] deff;
   always_comb begin
      if (dims_ff == 5'd0) deff = (DW+1)'(1);
      else if (dims_ff > 5'(DIM)) deff = (DW+1)'(DIM);
      else deff = dims_ff[DW:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dims_ff   <= 5'd4;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) staged_ff[i] <= 32'd0;
      end else begin
         state_ff  <= state_in;
         dims_ff   <= dims_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
         if (state_ff == S_IDLE && req_tvalid && req_tuser == FUNC_STAGE)
            staged_ff[req_tdata[3:0]] <= req_tdata[35:4];
      end
      func_ff <= func_in; q_ff <= q_in; dt_ff <= dt_in;
      lo_ff <= lo_in; len_ff <= len_in; tnext_ff <= tnext_in; tprev_ff <= tprev_in;
      u_ff <= u_in; ca_ff <= ca_in; j_ff <= j_in; st_ff <= st_in;
      odata_ff <= odata_in; ostat_ff <= ostat_in; olast_ff <= olast_in;
   end

   logic [CW-1:0] half, mid;
   logic signed [32:0] diff33;
   logic signed [FRAC_BITS+1:0] u_s;
   logic signed [FRAC_BITS+34:0] prod;
   logic signed [65:0] blend;
   logic signed [32:0] iv;
   logic [PW-1:0] pt_sel;

   always_comb begin
      state_in = state_ff; dims_in = csr_wen ? csr_wdata : dims_ff;
      count_in = count_ff; func_in = func_ff; q_in = q_ff; dt_in = dt_ff;
      lo_in = lo_ff; len_in = len_ff; tnext_in = tnext_ff; tprev_in = tprev_ff;
      u_in = u_ff; ca_in = ca_ff; j_in = j_ff; st_in = st_ff;
      odata_in = odata_ff; ostat_in = ostat_ff; olast_in = olast_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      req_tready = (state_ff == S_IDLE);
      t_we = 1'b0; c_we = 1'b0; t_addr = '0; c_addr = '0;
      t_wd = 32'd0; c_wd = 32'd0;
      dreq = '0;
      half = len_ff >> 1;
      mid  = lo_ff + half;
      diff33 = 33'(signed'(c_rd_ff)) - 33'(ca_ff);
      u_s = signed'({1'b0, u_ff});
      prod = diff33 * u_s;
      blend = 66'(ca_ff) + 66'(prod >>> FRAC_BITS);
      iv = 33'(tnext_ff) - 33'(tprev_ff);
      pt_sel = (st_ff == ST_CLAMP_FIRST) ? PW'(0) : PW'(count_ff - CW'(1));
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               dt_in = req_tdata[67:36];
               q_in = req_tdata[99:68];
               lo_in = '0; len_in = count_ff;
               j_in = '0;
               case (req_tuser)
                  FUNC_CLEAR: count_in = '0;
                  FUNC_APPEND: begin
                     if (count_ff >= CW'(MAX_POINTS)) begin
                        st_in = ST_FULL; state_in = S_OUT;
                     end else state_in = S_APP_RD;
                  end
                  FUNC_EVAL, FUNC_DERIV: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY; state_in = S_OUT;
                     end else state_in = S_SRCH_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_APP_RD: begin
            t_addr = PW'(count_ff - CW'(1));
            state_in = S_APP_WR; j_in = '0;
         end
         S_APP_WR: begin
            // write one coordinate per cycle, the time with the first
            c_we = 1'b1;
            c_addr = AW'(count_ff) * AW'(DIM) + AW'(j_ff);
            c_wd = staged_ff[4'(j_ff)];
            if (j_ff == '0) begin
               t_we = 1'b1; t_addr = PW'(count_ff);
               t_wd = (count_ff == '0) ? dt_ff
                    : sat32(66'(signed'(t_rd_ff)) + 66'(dt_ff));
            end
            if (32'(j_ff) == DIM - 1) begin
               count_in = count_ff + CW'(1);
               st_in = ST_OK; state_in = S_OUT;
            end else j_in = j_ff + DW'(1);
         end
         S_SRCH_RD: begin
            if (len_ff == '0) begin
               if (lo_ff == '0 || lo_ff >= count_ff) begin
                  st_in = (lo_ff == '0) ? ST_CLAMP_FIRST : ST_CLAMP_LAST;
                  state_in = S_CRD_RD;
               end else begin
                  t_addr = PW'(lo_ff);
                  state_in = S_PREV_RD;
               end
            end else begin
               t_addr = PW'(mid);
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (signed'(t_rd_ff) < q_ff) begin
               lo_in = mid + CW'(1);
               len_in = len_ff - half - CW'(1);
            end else len_in = half;
            state_in = S_SRCH_RD;
         end
         S_PREV_RD: begin
            t_addr = PW'(lo_ff - CW'(1));
            tnext_in = t_rd_ff;
            state_in = S_INTV;
         end
         S_INTV: begin
            tprev_in = t_rd_ff;
            if (33'(signed'(tnext_ff)) - 33'(signed'(t_rd_ff)) <= 33'sd0) begin
               st_in = ST_BAD_INTERVAL; state_in = S_OUT;
            end else begin
               st_in = ST_OK;
               if (func_ff == FUNC_EVAL) begin
                  dreq.start = 1'b1;
                  dreq.num = 64'(signed'(33'(q_ff) - 33'(signed'(t_rd_ff)))) <<< FRAC_BITS;
                  dreq.den = 32'(33'(signed'(tnext_ff)) - 33'(signed'(t_rd_ff)));
                  state_in = S_DIV_WAIT;
               end else state_in = S_CRD_RD;
            end
         end
         S_DIV_WAIT: begin
            if (drsp.done) begin
               if (signed'(drsp.quo) < 0) u_in = '0;
               else if (signed'(drsp.quo) > (64'sd1 <<< FRAC_BITS))
                  u_in = (FRAC_BITS+1)'(1) << FRAC_BITS;
               else u_in = drsp.quo[FRAC_BITS:0];
               state_in = S_CRD_RD;
            end
         end
         S_CRD_RD: begin
            if (!ovalid_ff || rsp_tready) begin
               if (st_ff == ST_OK)
                  c_addr = AW'(lo_ff - CW'(1)) * AW'(DIM) + AW'(j_ff);
               else c_addr = AW'(pt_sel) * AW'(DIM) + AW'(j_ff);
               state_in = S_CRD_A;
            end
         end
         S_CRD_A: begin
            ca_in = c_rd_ff;
            if (st_ff != ST_OK) begin
               odata_in = {4'd0, 4'(j_ff), (func_ff == FUNC_EVAL) ? c_rd_ff : 32'd0};
               ostat_in = st_ff; olast_in = ((DW+1)'(j_ff) + (DW+1)'(1) == deff);
               ovalid_in = 1'b1;
               state_in = olast_in ? S_IDLE : S_CRD_RD;
               j_in = j_ff + DW'(1);
            end else begin
               c_addr = AW'(lo_ff) * AW'(DIM) + AW'(j_ff);
               state_in = S_CRD_B;
            end
         end
         S_CRD_B: begin
            if (func_ff == FUNC_EVAL) begin
               odata_in = {4'd0, 4'(j_ff), sat32(blend)};
               ostat_in = ST_OK; olast_in = ((DW+1)'(j_ff) + (DW+1)'(1) == deff);
               ovalid_in = 1'b1;
               state_in = olast_in ? S_IDLE : S_CRD_RD;
               j_in = j_ff + DW'(1);
            end else begin
               dreq.start = 1'b1;
               dreq.num = 64'(diff33) <<< FRAC_BITS;
               dreq.den = iv[31:0];
               state_in = S_CRD_DIV;
            end
         end
         S_CRD_DIV: begin
            if (drsp.done) begin
               odata_in = {4'd0, 4'(j_ff), sat32(66'(signed'(drsp.quo)))};
               ostat_in = ST_OK; olast_in = ((DW+1)'(j_ff) + (DW+1)'(1) == deff);
               ovalid_in = 1'b1;
               state_in = olast_in ? S_IDLE : S_CRD_RD;
               j_in = j_ff + DW'(1);
            end
         end
         S_OUT: begin
            // single beat result, loaded only once the output register is free
            if (!ovalid_ff || rsp_tready) begin
               odata_in = '0; ostat_in = st_ff; olast_in = 1'b1;
               ovalid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ostat_ff;
   assign rsp_tlast  = olast_ff;
endmodule
`default_nettype wire

>>> rtl/plpe_checker.sv
// port-level checker for the path evaluator, bound to the top level
// uses assert_macros.svh and plpe_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module plpe_checker
   import plpe_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [2:0]  req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire [2:0]  rsp_tuser,
   input wire        rsp_tlast
);
   logic busy_func;
   assign busy_func = (req_tuser == FUNC_APPEND) || (req_tuser == FUNC_EVAL) ||
                      (req_tuser == FUNC_DERIV);

   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")
   `CHK_ALWAYS(a_stat, clock, reset, !rsp_tvalid || rsp_tuser <= ST_EMPTY, "undefined status")
   `CHK_ALWAYS(a_single, clock, reset, !rsp_tvalid || rsp_tuser == ST_OK || rsp_tuser == ST_CLAMP_FIRST || rsp_tuser == ST_CLAMP_LAST || rsp_tlast, "error status without last")
   `CHK_NEXT(a_busy, clock, reset, req_tvalid && req_tready && busy_func, !req_tready, "second beat accepted while busy")
endmodule
bind piecewise_linear_path_eval_top plpe_checker u_chk (.*);
`default_nettype wire

>>> test/path_eval_checker.sv
// checker for the piecewise linear path evaluator: mirrors path state and checks result beats
// depends on plpe_pkg; instantiated by testbench
`timescale 1ns / 1ps
module path_eval_checker
   import plpe_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int DIM        = 4,
   parameter int FRAC_BITS  = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [103:0] req_tdata,
   input  wire  [2:0]   req_tuser,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [39:0]  rsp_tdata,
   input  wire  [2:0]   rsp_tuser,
   input  wire          rsp_tlast,
   input  wire          csr_wen,
   input  wire  [4:0]   csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           beat_count
);
   typedef struct packed {
      logic [31:0] value;
      logic [3:0]  index;
      logic        last;
      status_type  status;
   } path_beat_type;

   path_beat_type expected_beats[$];
   logic signed [31:0] knot_time[MAX_POINTS];
   logic signed [31:0] knot_coord[MAX_POINTS][DIM];
   logic signed [31:0] staged[16];
   int unsigned knot_count;
   logic [4:0] dims_reg;

   assign pending_count = expected_beats.size();

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if (n < 0 && q * d != n) q = q - 1;
      return q;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic void push_beat(logic [31:0] v, int idx, bit lst, status_type st);
      path_beat_type b;
      b.value = v; b.index = idx[3:0]; b.last = lst; b.status = st;
      expected_beats = {expected_beats, b};
   endfunction

   task automatic predict_path(logic [2:0] fn, logic [103:0] data);
      logic [3:0] ci;
      longint cv, pdt, q, interval, one, u, a, b;
      int d, lo, len, half, mid, pt;
      status_type st;
      ci  = data[3:0];
      cv  = $signed(data[35:4]);
      pdt = $signed(data[67:36]);
      q   = $signed(data[99:68]);
      d   = (dims_reg == 0) ? 1 : (dims_reg > DIM ? DIM : dims_reg);
      one = longint'(1) << FRAC_BITS;
      case (fn)
         FUNC_STAGE: staged[ci] = cv[31:0];
         FUNC_CLEAR: knot_count = 0;
         FUNC_APPEND: begin
            if (knot_count >= MAX_POINTS) begin
               push_beat(0, 0, 1, ST_FULL);
            end else begin
               knot_time[knot_count] = (knot_count > 0) ?
                  clip32(longint'(knot_time[knot_count-1]) + pdt) : pdt[31:0];
               for (int j = 0; j < DIM; j++) knot_coord[knot_count][j] = staged[j];
               knot_count++;
               push_beat(0, 0, 1, ST_OK);
            end
         end
         FUNC_EVAL, FUNC_DERIV: begin
            if (knot_count == 0) begin
               push_beat(0, 0, 1, ST_EMPTY);
               return;
            end
            lo = 0; len = knot_count;
            while (len > 0) begin
               half = len / 2; mid = lo + half;
               if (longint'(knot_time[mid]) < q) begin
                  lo = mid + 1; len = len - half - 1;
               end else begin
                  len = half;
               end
            end
            if (lo == 0 || lo >= knot_count) begin
               pt = (lo == 0) ? 0 : knot_count - 1;
               st = (lo == 0) ? ST_CLAMP_FIRST : ST_CLAMP_LAST;
               for (int j = 0; j < d; j++)
                  push_beat((fn == FUNC_EVAL) ? knot_coord[pt][j] : 32'd0, j, j + 1 == d, st);
               return;
            end
            interval = longint'(knot_time[lo]) - longint'(knot_time[lo-1]);
            if (interval <= 0) begin
               push_beat(0, 0, 1, ST_BAD_INTERVAL);
               return;
            end
            u = floor_quot((q - knot_time[lo-1]) * one, interval);
            if (u < 0) u = 0;
            if (u > one) u = one;
            for (int j = 0; j < d; j++) begin
               a = knot_coord[lo-1][j];
               b = knot_coord[lo][j];
               if (fn == FUNC_EVAL)
                  push_beat(clip32(a + floor_quot((b - a) * u, one)), j, j + 1 == d, ST_OK);
               else
                  push_beat(clip32(floor_quot((b - a) * one, interval)), j, j + 1 == d, ST_OK);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      path_beat_type want;
      if (reset) begin
         knot_count = 0;
         dims_reg = 5'd4;
         for (int i = 0; i < 16; i++) staged[i] = 0;
         expected_beats.delete();
         fail_count <= 0;
         beat_count <= 0;
      end else begin
         if (csr_wen) dims_reg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            beat_count <= beat_count + 1;
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_tdata[31:0] !== want.value ||
                   rsp_tdata[35:32] !== want.index ||
                   rsp_tlast !== want.last || rsp_tuser !== want.status) begin
                  if (rsp_tdata[31:0] !== want.value)
                     $error("coord_out expected %h actual %h", want.value, rsp_tdata[31:0]);
                  if (rsp_tdata[35:32] !== want.index)
                     $error("coord_index_out expected %0d actual %0d", want.index,
                        rsp_tdata[35:32]);
                  if (rsp_tlast !== want.last)
                     $error("last expected %0d actual %0d", want.last, rsp_tlast);
                  if (rsp_tuser !== want.status)
                     $error("status expected %0d actual %0d", want.status, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) predict_path(req_tuser, req_tdata);
      end
   end
endmodule

>>> test/testbench.sv
// stimulus and verdict for the piecewise linear path evaluator
// depends on plpe_pkg, piecewise_linear_path_eval_top and path_eval_checker
`timescale 1ns / 1ps
module testbench;
   import plpe_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [39:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wen = 0;
   logic [4:0]   csr_wdata = '0;
   int           fail_count, pending_count, beat_count;
   int           send_idle_pct, recv_idle_pct;
   int           items_sent;

   always #10 clock = ~clock;

   piecewise_linear_path_eval_top dut (.*);
   path_eval_checker checker_inst (.*);

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // valid stays up between back to back beats and drops only on idle cycles
   task automatic send_item(func_type fn, int ci, logic [31:0] cv, logic [31:0] dt,
                            logic [31:0] q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= fn;
      req_tdata <= {4'd0, q, dt, cv, ci[3:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic set_dims(int dims);
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      csr_wen <= 1;
      csr_wdata <= dims[4:0];
      @(negedge clock);
      csr_wen <= 0;
   endtask

   // well-formed path: stage a vector then append with a positive step
   task automatic build_path(int points);
      for (int p = 0; p < points; p++) begin
         for (int j = 0; j < 4; j++) send_item(FUNC_STAGE, j, $urandom, 0, 0);
         send_item(FUNC_APPEND, 0, 0, $urandom_range(32'h40000, 1), 0);
      end
   endtask

   function automatic logic [31:0] pick_query();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h80000);
         default: return $urandom_range(32'h200000);
      endcase
   endfunction

   task automatic random_phase(int count);
      int k;
      k = 0;
      while (k < count) begin
         case ($urandom_range(9))
            0: begin send_item(FUNC_CLEAR, 0, 0, 0, 0); build_path($urandom_range(2, 1)); end
            1: send_item(FUNC_STAGE, $urandom_range(15), $urandom, 0, 0);
            2: send_item(FUNC_APPEND, 0, 0, $urandom, 0);
            3: send_item(func_type'($urandom_range(7)), $urandom_range(15), $urandom,
                         $urandom, $urandom);
            4, 5, 6: send_item(FUNC_EVAL, 0, 0, 0, pick_query());
            default: send_item(FUNC_DERIV, 0, 0, 0, pick_query());
         endcase
         k++;
      end
   endtask

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      items_sent = 0;
      send_idle_pct = 38;
      recv_idle_pct = 47;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty path, extremes, clamps, bad interval, full path
      send_item(FUNC_EVAL, 0, 0, 0, 0);
      send_item(FUNC_DERIV, 0, 0, 0, 32'h8000_0000);
      send_item(FUNC_STAGE, 0, 32'h7fff_ffff, 0, 0);
      send_item(FUNC_STAGE, 1, 32'h8000_0000, 0, 0);
      send_item(FUNC_STAGE, 15, 32'hffff_ffff, 0, 0);
      send_item(FUNC_APPEND, 0, 0, 32'h0001_0000, 0);
      send_item(FUNC_STAGE, 0, 32'h8000_0000, 0, 0);
      send_item(FUNC_STAGE, 1, 32'h7fff_ffff, 0, 0);
      send_item(FUNC_APPEND, 0, 0, 32'h0000_0001, 0);
      send_item(FUNC_EVAL, 0, 0, 0, 32'h0001_0000);
      send_item(FUNC_EVAL, 0, 0, 0, 32'h8000_0000);
      send_item(FUNC_EVAL, 0, 0, 0, 32'h7fff_ffff);
      send_item(FUNC_DERIV, 0, 0, 0, 32'h0001_0001);
      send_item(FUNC_EVAL, 0, 0, 0, 32'h0001_0001);
      // step of most negative value gives an unsorted time, then saturating add
      send_item(FUNC_APPEND, 0, 0, 32'h8000_0000, 0);
      send_item(FUNC_EVAL, 0, 0, 0, 32'h0001_0001);
      send_item(FUNC_APPEND, 0, 0, 32'h7fff_ffff, 0);
      send_item(FUNC_APPEND, 0, 0, 32'h7fff_ffff, 0);
      send_item(func_type'(3'd7), 15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_item(FUNC_CLEAR, 0, 0, 0, 0);
      for (int p = 0; p < 65; p++) send_item(FUNC_APPEND, 0, 0, 32'h0000_8000, 0);
      send_item(FUNC_DERIV, 0, 0, 0, 32'h0010_4000);
      send_item(FUNC_CLEAR, 0, 0, 0, 0);

      set_dims(1);
      build_path(2);
      random_phase(10);
      send_idle_pct = 47;
      recv_idle_pct = 38;
      set_dims(0);
      random_phase(8);
      set_dims(31);
      random_phase(8);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_dims(16);
      random_phase(6);
      set_dims(3);
      random_phase(6);

      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("covered %0d request beats and %0d result beats over five dims settings",
               items_sent, beat_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
